### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while rst is high
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, off while rst is high
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/rgb2hsl_pkg.sv
package rgb2hsl_pkg;

  localparam int CH_W      = 8;
  localparam int HUE_W     = 15;
  localparam int UNIT_W    = 16;
  localparam int DIV_QW    = 16;
  localparam int HUE_NUM_W = 20;
  localparam int SAT_NUM_W = 24;

  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 15'd23040;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [UNIT_W-1:0] saturation;
    logic [UNIT_W-1:0] lightness;
  } hsl_t;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              gray;
    logic [UNIT_W-1:0] light;
  } side_t;

endpackage

### rtl/rgb_to_hsl_converter_top.sv
// RGB to HSL pixel converter.
// Input channel pix (pix_valid, pix_stall) carries one 8-bit RGB pixel per item.
// Output channel hsl (hsl_valid, hsl_stall) carries hue in 1/64 degree units,
// saturation and lightness scaled so 65535 is 1.0, all floored.
// Throughput: one item per clock while hsl_stall is low.
// The pipeline has one stage for max, min and sector, one for numerators,
// sixteen for the radix-2 dividers (one quotient bit per stage for hue and for
// saturation), and one output register.
// Lightness needs no divider: 65535*sum/510 is 128*sum + sum/2.
// The whole pipeline moves on one enable; while hsl_valid is high and hsl_stall
// is high every stage holds, pix_stall is high, and the output item holds.
// Empty stages travel as bubbles with their valid bits cleared.
// Reset (rst, synchronous, active high) clears all valid bits; items in flight
// are dropped and hsl_valid is low in the cycle after reset.
module rgb_to_hsl_converter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  rgb2hsl_pkg::pix_t  pix,
  output logic               hsl_valid,
  input  logic               hsl_stall,
  output rgb2hsl_pkg::hsl_t  hsl
);
  import rgb2hsl_pkg::*;

  logic adv;

  sector_t           sec_c;
  logic [CH_W-1:0]   mx_c;
  logic [CH_W-1:0]   mn_c;
  logic [CH_W:0]     diff_c;

  logic              s1_valid;
  sector_t           s1_sector;
  logic              s1_neg;
  logic [CH_W-1:0]   s1_mag;
  logic [CH_W-1:0]   s1_d;
  logic [CH_W:0]     s1_sum;

  logic                 s2_valid;
  side_t                s2_side;
  logic [HUE_NUM_W-1:0] s2_hue_num;
  logic [SAT_NUM_W-1:0] s2_sat_num;
  logic [CH_W-1:0]      s2_d;
  logic [CH_W-1:0]      s2_den;

  logic [CH_W:0]     den_wide;
  logic [CH_W:0]     sum_rev;

  logic              dvld [DIV_QW];
  side_t             dside [DIV_QW];

  logic [DIV_QW-1:0] hue_quo;
  logic              hue_rem_nz;
  logic [DIV_QW-1:0] sat_quo;
  logic              sat_rem_nz;

  logic [HUE_W-1:0]  hue_q;
  logic [HUE_W-1:0]  hue_qc;
  logic [HUE_W-1:0]  hue_base;
  hsl_t              hsl_next;

  assign adv       = !hsl_valid || !hsl_stall;
  assign pix_stall = !adv;

  always_comb begin
    mx_c = pix.red;
    mn_c = pix.red;
    if (pix.green > mx_c) mx_c = pix.green;
    if (pix.blue  > mx_c) mx_c = pix.blue;
    if (pix.green < mn_c) mn_c = pix.green;
    if (pix.blue  < mn_c) mn_c = pix.blue;
    priority if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sec_c  = SEC_RED;
      diff_c = {1'b0, pix.green} - {1'b0, pix.blue};
    end else if (pix.green >= pix.blue) begin
      sec_c  = SEC_GREEN;
      diff_c = {1'b0, pix.blue} - {1'b0, pix.red};
    end else begin
      sec_c  = SEC_BLUE;
      diff_c = {1'b0, pix.red} - {1'b0, pix.green};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector <= sec_c;
      s1_neg    <= diff_c[CH_W];
      s1_mag    <= diff_c[CH_W] ? CH_W'(-diff_c) : diff_c[CH_W-1:0];
      s1_d      <= mx_c - mn_c;
      s1_sum    <= {1'b0, mx_c} + {1'b0, mn_c};
    end
  end

  assign sum_rev  = 9'd510 - s1_sum;
  assign den_wide = (s1_sum > 9'd255) ? sum_rev : s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side.sector <= s1_sector;
      s2_side.neg    <= s1_neg;
      s2_side.gray   <= (s1_d == '0);
      s2_side.light  <= {s1_sum, 7'b0} + UNIT_W'(s1_sum[CH_W:1]);
      s2_hue_num     <= {s1_mag, 12'b0} - {4'b0, s1_mag, 8'b0};
      s2_sat_num     <= {s1_d, 16'b0} - SAT_NUM_W'(s1_d);
      s2_d           <= s1_d;
      s2_den         <= den_wide[CH_W-1:0];
    end
  end

  rgb2hsl_div #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (CH_W),
    .Q_W   (DIV_QW)
  ) u_hue_div (
    .clk    (clk),
    .en     (adv),
    .num    (s2_hue_num),
    .den    (s2_d),
    .quo    (hue_quo),
    .rem_nz (hue_rem_nz)
  );

  rgb2hsl_div #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (CH_W),
    .Q_W   (DIV_QW)
  ) u_sat_div (
    .clk    (clk),
    .en     (adv),
    .num    (s2_sat_num),
    .den    (s2_den),
    .quo    (sat_quo),
    .rem_nz (sat_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_QW; i++) dvld[i] <= 1'b0;
    end else if (adv) begin
      dvld[0] <= s2_valid;
      for (int i = 1; i < DIV_QW; i++) dvld[i] <= dvld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= s2_side;
      for (int i = 1; i < DIV_QW; i++) dside[i] <= dside[i-1];
    end
  end

  always_comb begin
    hue_q  = HUE_W'(hue_quo[11:0]);
    hue_qc = hue_q + HUE_W'(hue_rem_nz);
    unique case (dside[DIV_QW-1].sector)
      SEC_RED:   hue_base = dside[DIV_QW-1].neg ? HUE_FULL_TURN : '0;
      SEC_GREEN: hue_base = HUE_GREEN_BASE;
      SEC_BLUE:  hue_base = HUE_BLUE_BASE;
      default:   hue_base = '0;
    endcase
    hsl_next.lightness = dside[DIV_QW-1].light;
    if (dside[DIV_QW-1].gray) begin
      hsl_next.hue        = '0;
      hsl_next.saturation = '0;
    end else begin
      hsl_next.hue        = dside[DIV_QW-1].neg ? hue_base - hue_qc : hue_base + hue_q;
      hsl_next.saturation = sat_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else if (adv) begin
      hsl_valid <= dvld[DIV_QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hsl <= hsl_next;
    end
  end

  logic unused_ok;
  assign unused_ok = sat_rem_nz;

endmodule

### rtl/rgb2hsl_div.sv
module rgb2hsl_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             rem_nz
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      always_comb begin
        rem_in = DEN_W'(num[NUM_W-1:Q_W]);
        low_in = num[Q_W-1:0];
        quo_in = '0;
        den_in = den;
      end
    end else begin : g_next
      always_comb begin
        rem_in = rem_q[i-1];
        low_in = low_q[i-1];
        quo_in = quo_q[i-1];
        den_in = den_q[i-1];
      end
    end

    always_comb begin
      trial = {rem_in, low_in[Q_W-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[i] <= {low_in[Q_W-2:0], 1'b0};
        quo_q[i] <= {quo_in[Q_W-2:0], ge};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo    = quo_q[Q_W-1];
  assign rem_nz = |rem_q[Q_W-1];

endmodule

### rtl/rgb2hsl_chk.sv
`include "assert_macros.svh"

module rgb2hsl_chk (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_stall,
  input rgb2hsl_pkg::pix_t  pix,
  input logic               hsl_valid,
  input logic               hsl_stall,
  input rgb2hsl_pkg::hsl_t  hsl
);
  import rgb2hsl_pkg::*;

  `ASSERT_NEXT(a_out_hold, hsl_valid && hsl_stall, hsl_valid && $stable(hsl))
  `ASSERT_IMPL(a_stall_cause, pix_stall, hsl_valid && hsl_stall)
  `ASSERT_IMPL(a_hue_range, hsl_valid, hsl.hue < HUE_FULL_TURN)
  `ASSERT_NEXT_ALWAYS(a_reset_clear, rst, !hsl_valid)

endmodule

bind rgb_to_hsl_converter_top rgb2hsl_chk u_rgb2hsl_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rgb2hsl_pkg::*;

  localparam int HUE_SECTOR    = 3840;
  localparam int UNIT_MAX      = 65535;
  localparam int RANDOM_PIXELS = 1750;
  localparam int QUIET_FROM    = 700;
  localparam int QUIET_TO      = 1000;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_AT      = 1300;
  localparam int TAIL_CYCLES   = 40;
  localparam int STUCK_LIMIT   = 2000;

  localparam bit [23:0] DIRECTED [22] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hC8C832, 24'h32C8C8, 24'hC832C8,
    24'hFF0001, 24'hFF0100, 24'h010000, 24'hFFFEFE, 24'h807F7F, 24'h01FF00,
    24'h0001FF, 24'hAA5500, 24'h7F8000, 24'h641EDC
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_t pix = '0;
  logic hsl_valid;
  logic hsl_stall = 1'b0;
  hsl_t hsl;

  pix_t pix_pending [$];
  hsl_t hsl_expected [$];
  int   pix_sent = 0;
  int   hsl_got = 0;
  int   mismatches = 0;
  int   stuck_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   drain_done = 1'b0;

  rgb_to_hsl_converter_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hsl       (hsl)
  );

  always #4 clk = ~clk;

  function automatic int floored_quot(int n, int d);
    return (n >= 0) ? n / d : -((-n + d - 1) / d);
  endfunction

  function automatic hsl_t hsl_of_pixel(pix_t p);
    int r, g, b, peak, base, span, total, denom, h, s, l;
    hsl_t res;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    peak = (r > g) ? r : g;
    peak = (b > peak) ? b : peak;
    base = (r < g) ? r : g;
    base = (b < base) ? b : base;
    span = peak - base;
    total = peak + base;
    h = 0;
    s = 0;
    if (span != 0) begin
      if (peak == r) begin
        h = floored_quot(HUE_SECTOR * (g - b), span);
        if (h < 0) h += int'(HUE_FULL_TURN);
      end else if (peak == g) begin
        h = int'(HUE_GREEN_BASE) + floored_quot(HUE_SECTOR * (b - r), span);
      end else begin
        h = int'(HUE_BLUE_BASE) + floored_quot(HUE_SECTOR * (r - g), span);
      end
      denom = (total > 255) ? 510 - total : total;
      s = UNIT_MAX * span / denom;
      if (s > UNIT_MAX) s = UNIT_MAX;
    end
    l = UNIT_MAX * total / 510;
    res.hue = h[HUE_W-1:0];
    res.saturation = s[UNIT_W-1:0];
    res.lightness = l[UNIT_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        hsl_expected.push_back(hsl_of_pixel(pix));
        pix_sent++;
      end
      if (pix_sent >= DRAIN_AT && !drain_done && hsl_expected.size() == 0) drain_done = 1'b1;
      if (!(pix_valid && pix_stall)) begin
        if (pix_pending.size() > 0 && !(pix_sent >= DRAIN_AT && !drain_done) &&
            ((pix_sent >= QUIET_FROM && pix_sent < QUIET_TO) || $urandom_range(99) >= 7)) begin
          pix <= pix_pending.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      hsl_stall <= 1'b0;
    end else begin
      if (hsl_valid && !hsl_stall) begin
        if (hsl_expected.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %p", $time, hsl);
          mismatches++;
        end else begin
          hsl_t want;
          want = hsl_expected.pop_front();
          check_field("hue", 32'(want.hue), 32'(hsl.hue));
          check_field("saturation", 32'(want.saturation), 32'(hsl.saturation));
          check_field("lightness", 32'(want.lightness), 32'(hsl.lightness));
        end
        hsl_got++;
      end
      if (!hold_done && hsl_got >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hsl_stall <= 1'b1;
        hold_left--;
      end else begin
        hsl_stall <= !(hsl_got >= QUIET_FROM && hsl_got < QUIET_TO) &&
                     ($urandom_range(99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_valid && !pix_stall) || (hsl_valid && !hsl_stall))
      stuck_cycles <= 0;
    else if (pix_pending.size() > 0 || pix_valid || hsl_expected.size() > 0)
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    pix_t p;
    int unsigned top, pick;
    bit [7:0] corner [6];
    corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    foreach (DIRECTED[i]) pix_pending.push_back(pix_t'(DIRECTED[i]));
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      p = pix_t'(24'($urandom));
      case ($urandom_range(9))
        0: begin
          p.green = p.red;
          p.blue = p.red;
        end
        1: begin
          top = $urandom_range(255);
          pick = $urandom_range(2);
          p.red = 8'((pick != 2) ? top : $urandom_range(top));
          p.green = 8'((pick != 1) ? top : $urandom_range(top));
          p.blue = 8'((pick != 0) ? top : $urandom_range(top));
        end
        2: begin
          p.red = corner[$urandom_range(5)];
          p.green = corner[$urandom_range(5)];
          p.blue = corner[$urandom_range(5)];
        end
        default: ;
      endcase
      pix_pending.push_back(p);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pix_pending.size() > 0 || pix_valid || hsl_expected.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
